// ===== src/eps_pkg.sv =====
`default_nettype none

package eps_pkg;

	// Field widths
	localparam int CHAN_W     = 2;
	localparam int CAP_W      = 16;
	localparam int SCALE_W    = 20;
	localparam int PERIOD_W   = 16;
	localparam int SPA_W      = 8;
	localparam int GLITCH_W   = 24;
	localparam int TMO_W      = 4;
	localparam int OVF_W      = 4;
	localparam int ACC_W      = 40;
	localparam int SPEED_W    = 32;
	localparam int WIDTH_W    = 20;  // clamped pulse width, at most 16 periods of 16 bits
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	// Register reset values
	localparam logic [SCALE_W-1:0]  SCALE_RST   = 20'd100000;
	localparam logic [PERIOD_W-1:0] PERIOD_RST  = 16'd10000;
	localparam logic [SPA_W-1:0]    SPA_RST     = 8'd10;
	localparam logic [GLITCH_W-1:0] GLITCH_RST  = 24'd5120;
	localparam logic [TMO_W-1:0]    TMO_RST     = 4'd3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SPEED_SCALE   = 3'd0,
		REG_TIMER_PERIOD  = 3'd1,
		REG_SAMPLES       = 3'd2,
		REG_GLITCH        = 3'd3,
		REG_TIMEOUT       = 3'd4
	} cfg_reg_t;

	typedef enum logic {
		REQ_EDGE = 1'b0,
		REQ_TICK = 1'b1
	} req_type_t;

	typedef struct packed {
		req_type_t         req_type;
		logic [CHAN_W-1:0] channel;
		logic [CAP_W-1:0]  capture_value;
		logic              dir_pin;
	} evt_word_t;

	typedef struct packed {
		logic [CHAN_W-1:0]         out_channel;
		logic signed [SPEED_W-1:0] speed;
		logic                      speed_updated;
	} res_word_t;

	// Per-channel state held in the channel memory
	typedef struct packed {
		logic                      awaiting_fall;
		logic [CAP_W-1:0]          rise_stamp;
		logic                      backward_dir;
		logic [OVF_W-1:0]          overflow_count;
		logic signed [ACC_W-1:0]   speed_accum;
		logic [SPA_W-1:0]          sample_count;
		logic signed [SPEED_W-1:0] speed_value;
		logic                      first_done;
	} chan_state_t;

	// Divider status toward its user
	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

endpackage

`default_nettype wire

// ===== src/eps_stream_if.sv =====
`default_nettype none

interface eps_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== src/encoder_pulse_speed_estimator_unit.sv =====
// Path from accept to registered result: a tick or rising edge goes EXEC then WB (straight to WB
// if the channel is out of range), a falling edge EXEC, TDIV, ACC, MCHK, WB, and one that closes
// an average adds MDIV and BLEND before WB. Both divides use the shared bit-serial divider, whose
// dividend is DVD_W = max(20 + FRAC_BITS, 40) bits, 40 by default. One word is in flight; the next
// is accepted the cycle after its result is registered, and a stalled result holds it off.
// Reset: config registers to defaults; valid flags clear, unwritten channels read as zero.
`default_nettype none

module encoder_pulse_speed_estimator_unit
	import eps_pkg::*;
#(
	parameter int NUM_CHANNELS = 4,
	parameter int FRAC_BITS    = 8
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	eps_stream_if.sink                 evt,
	eps_stream_if.source               res,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam int ADDR_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int NUM_W  = SCALE_W + FRAC_BITS;
	localparam int DVD_W  = (NUM_W > ACC_W) ? NUM_W : ACC_W;
	localparam int TERM_W = NUM_W + 1;
	localparam int SUM_W  = ((TERM_W > ACC_W) ? TERM_W : ACC_W) + 1;
	localparam int WID_W  = WIDTH_W + 2;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_EXEC  = 8'b0000_0010,
		S_TDIV  = 8'b0000_0100,
		S_ACC   = 8'b0000_1000,
		S_MCHK  = 8'b0001_0000,
		S_MDIV  = 8'b0010_0000,
		S_BLEND = 8'b0100_0000,
		S_WB    = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	// configuration registers
	logic [SCALE_W-1:0]  scale_q;
	logic [PERIOD_W-1:0] period_q;
	logic [SPA_W-1:0]    spa_q;
	logic [GLITCH_W-1:0] glitch_q;
	logic [TMO_W-1:0]    tmo_q;

	// channel memory and valid flags
	chan_state_t             mem_q [NUM_CHANNELS];
	chan_state_t             rdata_q;
	logic                    ent_vld_q;
	logic [NUM_CHANNELS-1:0] vld_q;
	logic                    mem_we;
	logic [ADDR_W-1:0]       rd_addr;
	logic [ADDR_W-1:0]       wr_addr;
	logic                    evt_acc;
	logic                    evt_oor;

	// working registers
	evt_word_t                 evt_q;
	logic                      oor_q;
	chan_state_t               cur_q;
	logic signed [SPEED_W-1:0] old_speed_q;
	logic signed [SPEED_W-1:0] mean_q;
	res_word_t                 res_q;
	logic                      res_vld_q;
	logic                      res_load;

	// combinational
	chan_state_t          st;
	chan_state_t          exec_nxt;
	logic [OVF_W-1:0]     ovf_inc;
	logic [WIDTH_W-1:0]   prod;
	logic signed [WID_W-1:0] wid;
	logic [WIDTH_W-1:0]   wid_cl;
	logic                 is_fall;
	logic [SPA_W-1:0]     n_eff;
	logic [TERM_W-1:0]    term;
	logic [SUM_W-1:0]     acc_sum;
	logic [ACC_W-1:0]     acc_sat;
	logic [ACC_W-1:0]     acc_abs;
	logic [ACC_W:0]       mean_ext;
	logic [SPEED_W-1:0]   mean_sat;
	logic [SPEED_W:0]     bl_sum;
	logic [SPEED_W:0]     bl_abs;
	logic [SPEED_W:0]     bl_rnd;
	logic                 bl_take;

	// divider hookup
	logic             div_start;
	logic [DVD_W-1:0] div_dvd;
	logic [WIDTH_W-1:0] div_dvs;
	logic [DVD_W-1:0] div_quo;
	div_sts_t         div_sts;

	eps_div #(
		.DVD_W (DVD_W),
		.DVS_W (WIDTH_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.quotient (div_quo),
		.sts      (div_sts)
	);

	// handshake
	assign evt.ready = (state_q == S_IDLE);
	assign evt_acc   = evt.valid && (state_q == S_IDLE);
	assign evt_oor   = !(32'(evt.data.channel) < NUM_CHANNELS);
	assign rd_addr   = ADDR_W'(evt.data.channel);
	assign wr_addr   = ADDR_W'(evt_q.channel);
	assign res_load  = (state_q == S_WB) && (!res_vld_q || res.ready);
	assign mem_we    = res_load && !oor_q;
	assign res.valid = res_vld_q;
	assign res.data  = res_q;

	// entry as read; never-written entries read as zero
	assign st = ent_vld_q ? rdata_q : '0;

	// tick / rising / falling update of the entry
	assign ovf_inc = st.overflow_count + 1'b1;
	assign is_fall = (evt_q.req_type == REQ_EDGE) && st.awaiting_fall;

	always_comb begin
		exec_nxt = st;
		if (evt_q.req_type == REQ_TICK) begin
			exec_nxt.overflow_count = ovf_inc;
			if (ovf_inc >= tmo_q) begin
				exec_nxt.overflow_count = '0;
				exec_nxt.speed_value    = '0;
			end
		end else if (!st.awaiting_fall) begin
			exec_nxt.awaiting_fall  = 1'b1;
			exec_nxt.rise_stamp     = evt_q.capture_value;
			exec_nxt.overflow_count = '0;
			exec_nxt.backward_dir   = evt_q.dir_pin;
		end else begin
			exec_nxt.awaiting_fall = 1'b0;
		end
	end

	// pulse width, clamped to at least one count
	assign prod = WIDTH_W'(period_q) * WIDTH_W'(st.overflow_count);
	assign wid  = $signed(WID_W'(evt_q.capture_value)) - $signed(WID_W'(st.rise_stamp))
		+ $signed(WID_W'(prod));
	assign wid_cl = (wid < $signed(WID_W'(1))) ? WIDTH_W'(1) : wid[WIDTH_W-1:0];

	// signed speed term and saturating accumulate
	assign n_eff = (spa_q == '0) ? SPA_W'(1) : spa_q;
	assign term  = cur_q.backward_dir ? -{1'b0, div_quo[NUM_W-1:0]}
		: {1'b0, div_quo[NUM_W-1:0]};
	assign acc_sum = SUM_W'($signed(term)) + SUM_W'(cur_q.speed_accum);

	always_comb begin
		if ((acc_sum[SUM_W-1:ACC_W-1] == '0) || (acc_sum[SUM_W-1:ACC_W-1] == '1)) begin
			acc_sat = acc_sum[ACC_W-1:0];
		end else if (acc_sum[SUM_W-1]) begin
			acc_sat = {1'b1, {(ACC_W-1){1'b0}}};
		end else begin
			acc_sat = {1'b0, {(ACC_W-1){1'b1}}};
		end
	end

	// mean: magnitude divide, sign restored, saturated to 32 bits
	assign acc_abs  = cur_q.speed_accum[ACC_W-1] ? -cur_q.speed_accum : cur_q.speed_accum;
	assign mean_ext = cur_q.speed_accum[ACC_W-1] ? -{1'b0, div_quo[ACC_W-1:0]}
		: {1'b0, div_quo[ACC_W-1:0]};

	always_comb begin
		if ((mean_ext[ACC_W:SPEED_W-1] == '0) || (mean_ext[ACC_W:SPEED_W-1] == '1)) begin
			mean_sat = mean_ext[SPEED_W-1:0];
		end else if (mean_ext[ACC_W]) begin
			mean_sat = {1'b1, {(SPEED_W-1){1'b0}}};
		end else begin
			mean_sat = {1'b0, {(SPEED_W-1){1'b1}}};
		end
	end

	// blend with old speed, halved toward zero; small sums are dropped
	assign bl_sum  = {mean_q[SPEED_W-1], mean_q}
		+ {cur_q.speed_value[SPEED_W-1], cur_q.speed_value};
	assign bl_abs  = bl_sum[SPEED_W] ? -bl_sum : bl_sum;
	assign bl_rnd  = bl_sum + {{SPEED_W{1'b0}}, bl_sum[SPEED_W]};
	assign bl_take = (bl_abs >= (SPEED_W+1)'(glitch_q));

	// divider operand select
	always_comb begin
		div_start = 1'b0;
		div_dvd   = DVD_W'(scale_q) << FRAC_BITS;
		div_dvs   = wid_cl;
		if (state_q == S_EXEC) begin
			div_start = is_fall;
		end else if (state_q == S_MCHK) begin
			div_start = !(cur_q.sample_count < n_eff);
			div_dvd   = DVD_W'(acc_abs);
			div_dvs   = WIDTH_W'(n_eff);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (evt.valid) begin
					state_d = evt_oor ? S_WB : S_EXEC;
				end
			end
			S_EXEC:  state_d = is_fall ? S_TDIV : S_WB;
			S_TDIV:  if (div_sts.done) state_d = S_ACC;
			S_ACC:   state_d = S_MCHK;
			S_MCHK:  state_d = (cur_q.sample_count < n_eff) ? S_WB : S_MDIV;
			S_MDIV:  if (div_sts.done) state_d = S_BLEND;
			S_BLEND: state_d = S_WB;
			S_WB:    if (res_load) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			res_vld_q <= 1'b0;
			vld_q     <= '0;
			scale_q   <= SCALE_RST;
			period_q  <= PERIOD_RST;
			spa_q     <= SPA_RST;
			glitch_q  <= GLITCH_RST;
			tmo_q     <= TMO_RST;
		end else begin
			state_q <= state_d;
			if (res_load) begin
				res_vld_q <= 1'b1;
			end else if (res.ready) begin
				res_vld_q <= 1'b0;
			end
			if (mem_we) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (cfg_we) begin
				unique case (cfg_reg_t'(cfg_idx))
					REG_SPEED_SCALE:  scale_q  <= cfg_wdata[SCALE_W-1:0];
					REG_TIMER_PERIOD: period_q <= cfg_wdata[PERIOD_W-1:0];
					REG_SAMPLES:      spa_q    <= cfg_wdata[SPA_W-1:0];
					REG_GLITCH:       glitch_q <= cfg_wdata[GLITCH_W-1:0];
					REG_TIMEOUT:      tmo_q    <= cfg_wdata[TMO_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// channel memory: registered read, write-back at end of word
	always_ff @(posedge clk) begin
		if (evt_acc && !evt_oor) begin
			rdata_q   <= mem_q[rd_addr];
			ent_vld_q <= vld_q[rd_addr];
		end
		if (mem_we) begin
			mem_q[wr_addr] <= cur_q;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (evt_acc) begin
			evt_q <= evt.data;
			oor_q <= evt_oor;
		end
		case (state_q)
			S_EXEC: begin
				cur_q       <= exec_nxt;
				old_speed_q <= st.speed_value;
			end
			S_ACC: begin
				cur_q.speed_accum  <= acc_sat;
				cur_q.sample_count <= cur_q.sample_count + 1'b1;
			end
			S_MDIV: begin
				if (div_sts.done) begin
					mean_q <= mean_sat;
				end
			end
			S_BLEND: begin
				if (!cur_q.first_done) begin
					cur_q.first_done  <= 1'b1;
					cur_q.speed_value <= mean_q;
				end else if (bl_take) begin
					cur_q.speed_value <= bl_rnd[SPEED_W:1];
				end
				cur_q.sample_count <= '0;
				cur_q.speed_accum  <= '0;
			end
			default: ;
		endcase
		if (res_load) begin
			res_q.out_channel   <= evt_q.channel;
			res_q.speed         <= oor_q ? '0 : cur_q.speed_value;
			res_q.speed_updated <= !oor_q && (cur_q.speed_value != old_speed_q);
		end
	end

	// checks
	a_div_done_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		div_sts.done |-> (state_q == S_TDIV || state_q == S_MDIV))
		else $error("divider finished outside a wait state");

	a_div_start_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_sts.busy)
		else $error("divider started while busy");

	a_wb_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |=> (state_q == S_IDLE) && res_vld_q)
		else $error("write-back did not return to idle with a result");

	a_accept_path: assert property (@(posedge clk) disable iff (!arst_n)
		(evt.valid && evt.ready) |=> (state_q == S_EXEC || state_q == S_WB))
		else $error("accepted word took no valid path");

endmodule

`default_nettype wire

// ===== src/eps_div.sv =====
`default_nettype none

// Restoring unsigned divider, one quotient bit per cycle
module eps_div
	import eps_pkg::*;
#(
	parameter int DVD_W = 40,
	parameter int DVS_W = 20
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [DVD_W-1:0] dividend,
	input  wire logic [DVS_W-1:0] divisor,
	output      logic [DVD_W-1:0] quotient,
	output      div_sts_t         sts
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [DVD_W-1:0] quo_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DVS_W:0]   trial;
	logic [DVS_W:0]   diff;

	// one trial subtraction per cycle
	assign trial = {rem_q, quo_q[DVD_W-1]};
	assign diff  = trial - {1'b0, dvs_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DVD_W-2:0], ~diff[DVS_W]};
			rem_q <= diff[DVS_W] ? trial[DVS_W-1:0] : diff[DVS_W-1:0];
		end
	end

	assign quotient = quo_q;
	assign sts      = '{busy: busy_q, done: done_q};

endmodule

`default_nettype wire

// ===== dv/encoder_pulse_speed_estimator_unit_tb.sv =====
`timescale 1ns / 100ps

module encoder_pulse_speed_estimator_unit_tb
	import eps_pkg::*;
();

	localparam int FRAC_BITS   = 8;
	localparam int STALL_LIMIT = 4000;

	typedef enum {
		ROW_EVENT,
		ROW_WRITE
	} row_kind_t;

	typedef struct {
		row_kind_t             kind;
		req_type_t             req;
		logic [CHAN_W-1:0]     ch;
		logic [CAP_W-1:0]      cap;
		logic                  dir;
		bit                    typed;
		int                    speed;
		bit                    upd;
		cfg_reg_t              widx;
		logic [CFG_DATA_W-1:0] wval;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	eps_stream_if #(.T(evt_word_t)) evt_if ();
	eps_stream_if #(.T(res_word_t)) res_if ();

	encoder_pulse_speed_estimator_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt       (evt_if),
		.res       (res_if),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	// Directed words; reset defaults apply until the first register write
	stim_row_t directed_rows [26] = '{
		'{ROW_EVENT, REQ_TICK, 2'd0, 16'd0,     1'b0, 1'b1, 0,      1'b0, REG_SPEED_SCALE, 24'd0},
		'{ROW_EVENT, REQ_EDGE, 2'd0, 16'd0,     1'b0, 1'b1, 0,      1'b0, REG_SPEED_SCALE, 24'd0},
		'{ROW_EVENT, REQ_EDGE, 2'd0, 16'd65535, 1'b0, 1'b1, 0,      1'b0, REG_SPEED_SCALE, 24'd0},
		'{ROW_EVENT, REQ_EDGE, 2'd1, 16'd65535, 1'b1, 1'b1, 0,      1'b0, REG_SPEED_SCALE, 24'd0},
		'{ROW_EVENT, REQ_EDGE, 2'd1, 16'd0,     1'b0, 1'b1, 0,      1'b0, REG_SPEED_SCALE, 24'd0},
		'{ROW_EVENT, REQ_EDGE, 2'd2, 16'd100,   1'b0, 1'b1, 0,      1'b0, REG_SPEED_SCALE, 24'd0},
		'{ROW_EVENT, REQ_TICK, 2'd2, 16'd65535, 1'b1, 1'b1, 0,      1'b0, REG_SPEED_SCALE, 24'd0},
		'{ROW_EVENT, REQ_TICK, 2'd2, 16'd0,     1'b0, 1'b1, 0,      1'b0, REG_SPEED_SCALE, 24'd0},
		'{ROW_EVENT, REQ_EDGE, 2'd2, 16'd50,    1'b0, 1'b1, 0,      1'b0, REG_SPEED_SCALE, 24'd0},
		'{ROW_EVENT, REQ_TICK, 2'd3, 16'd0,     1'b0, 1'b1, 0,      1'b0, REG_SPEED_SCALE, 24'd0},
		'{ROW_EVENT, REQ_TICK, 2'd3, 16'd0,     1'b0, 1'b1, 0,      1'b0, REG_SPEED_SCALE, 24'd0},
		'{ROW_EVENT, REQ_TICK, 2'd3, 16'd0,     1'b0, 1'b1, 0,      1'b0, REG_SPEED_SCALE, 24'd0},
		'{ROW_WRITE, REQ_EDGE, 2'd0, 16'd0,     1'b0, 1'b0, 0,      1'b0, REG_SAMPLES,     24'd1},
		'{ROW_EVENT, REQ_EDGE, 2'd3, 16'd0,     1'b0, 1'b1, 0,      1'b0, REG_SPEED_SCALE, 24'd0},
		'{ROW_EVENT, REQ_EDGE, 2'd3, 16'd100,   1'b0, 1'b1, 256000, 1'b1, REG_SPEED_SCALE, 24'd0},
		'{ROW_EVENT, REQ_EDGE, 2'd3, 16'd200,   1'b1, 1'b1, 256000, 1'b0, REG_SPEED_SCALE, 24'd0},
		'{ROW_EVENT, REQ_EDGE, 2'd3, 16'd300,   1'b0, 1'b1, 256000, 1'b0, REG_SPEED_SCALE, 24'd0},
		'{ROW_EVENT, REQ_EDGE, 2'd3, 16'd0,     1'b0, 1'b1, 256000, 1'b0, REG_SPEED_SCALE, 24'd0},
		'{ROW_EVENT, REQ_EDGE, 2'd3, 16'd50,    1'b0, 1'b1, 384000, 1'b1, REG_SPEED_SCALE, 24'd0},
		'{ROW_EVENT, REQ_TICK, 2'd3, 16'd0,     1'b0, 1'b1, 384000, 1'b0, REG_SPEED_SCALE, 24'd0},
		'{ROW_EVENT, REQ_TICK, 2'd3, 16'd0,     1'b0, 1'b1, 384000, 1'b0, REG_SPEED_SCALE, 24'd0},
		'{ROW_EVENT, REQ_TICK, 2'd3, 16'd0,     1'b0, 1'b1, 0,      1'b1, REG_SPEED_SCALE, 24'd0},
		'{ROW_EVENT, REQ_EDGE, 2'd0, 16'd1000,  1'b0, 1'b0, 0,      1'b0, REG_SPEED_SCALE, 24'd0},
		'{ROW_EVENT, REQ_EDGE, 2'd0, 16'd1000,  1'b0, 1'b0, 0,      1'b0, REG_SPEED_SCALE, 24'd0},
		'{ROW_WRITE, REQ_EDGE, 2'd0, 16'd0,     1'b0, 1'b0, 0,      1'b0, REG_TIMEOUT,     24'd1},
		'{ROW_EVENT, REQ_TICK, 2'd1, 16'd0,     1'b0, 1'b0, 0,      1'b0, REG_SPEED_SCALE, 24'd0}
	};

	// Estimator copy: configuration
	logic [SCALE_W-1:0]  scale_cfg  = SCALE_RST;
	logic [PERIOD_W-1:0] period_cfg = PERIOD_RST;
	logic [SPA_W-1:0]    spa_cfg    = SPA_RST;
	logic [GLITCH_W-1:0] glitch_cfg = GLITCH_RST;
	logic [TMO_W-1:0]    tmo_cfg    = TMO_RST;

	// Estimator copy: per-channel state
	logic                      arm_st   [4];
	logic [CAP_W-1:0]          rise_st  [4];
	logic                      back_st  [4];
	logic [OVF_W-1:0]          ovf_st   [4];
	logic signed [ACC_W-1:0]   acc_st   [4];
	logic [SPA_W-1:0]          cnt_st   [4];
	logic signed [SPEED_W-1:0] spd_st   [4];
	logic                      first_st [4];

	res_word_t pending_reports [$];

	int mismatches = 0;
	int n_ticks    = 0;
	int n_falls    = 0;
	int n_checked  = 0;
	int n_changes  = 0;

	bit no_idle       = 1'b0;
	bit long_hold_req = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	// Gap length for either side: mostly none or short, now and then long
	function automatic int unsigned pick_gap();
		int unsigned r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(25, 80);
	endfunction

	// Advance the estimator copy by one event word and give the expected report
	task automatic estimate_speed(input evt_word_t w, output res_word_t r);
		logic [CHAN_W-1:0]         c;
		logic signed [SPEED_W-1:0] old;
		logic [SPA_W-1:0]          n;
		longint                    width;
		longint                    term;
		longint                    acc;
		longint                    mean;
		longint                    sum;
		c = w.channel;
		old = spd_st[c];
		if (w.req_type == REQ_TICK) begin
			n_ticks++;
			ovf_st[c] = ovf_st[c] + 4'd1;
			if (ovf_st[c] >= tmo_cfg) begin
				ovf_st[c] = '0;
				spd_st[c] = '0;
			end
		end else if (!arm_st[c]) begin
			// rising edge: stamp, direction, overflow restart
			arm_st[c] = 1'b1;
			rise_st[c] = w.capture_value;
			ovf_st[c] = '0;
			back_st[c] = w.dir_pin;
		end else begin
			n_falls++;
			arm_st[c] = 1'b0;
			width = longint'(w.capture_value) - longint'(rise_st[c])
				+ longint'(period_cfg) * longint'(ovf_st[c]);
			if (width < 1)
				width = 1;
			term = (longint'(scale_cfg) << FRAC_BITS) / width;
			if (back_st[c])
				term = -term;
			acc = acc_st[c] + term;
			if (acc > 64'sd549755813887)
				acc = 64'sd549755813887;
			if (acc < -64'sd549755813888)
				acc = -64'sd549755813888;
			acc_st[c] = ACC_W'(acc);
			cnt_st[c] = cnt_st[c] + 8'd1;
			n = (spa_cfg == '0) ? 8'd1 : spa_cfg;
			if (cnt_st[c] >= n) begin
				mean = clamp32(acc / longint'(n));
				if (!first_st[c]) begin
					first_st[c] = 1'b1;
					spd_st[c] = SPEED_W'(mean);
				end else begin
					// blend with old speed unless the pair nearly cancels
					sum = mean + longint'(spd_st[c]);
					if ((sum < 0 ? -sum : sum) >= longint'(glitch_cfg))
						spd_st[c] = SPEED_W'(clamp32(sum / 2));
				end
				cnt_st[c] = '0;
				acc_st[c] = '0;
			end
		end
		r.out_channel = c;
		r.speed = spd_st[c];
		r.speed_updated = (spd_st[c] != old);
	endtask

	// Offer one word after a random gap; record the expected report on accept
	task automatic send_event(input evt_word_t w, input bit typed, input int t_speed,
			input bit t_upd);
		int unsigned gap;
		res_word_t   e;
		gap = pick_gap();
		if (gap > 0) begin
			evt_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		evt_if.valid <= 1'b1;
		evt_if.data <= w;
		do @(posedge clk); while (!evt_if.ready);
		estimate_speed(w, e);
		if (typed) begin
			e.speed = t_speed;
			e.speed_updated = t_upd;
		end
		pending_reports.push_back(e);
	endtask

	// Stop offering and wait until every report is back
	task automatic wait_for_reports();
		evt_if.valid <= 1'b0;
		do @(posedge clk); while (pending_reports.size() != 0);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		case (idx)
			REG_SPEED_SCALE:  scale_cfg = val[SCALE_W-1:0];
			REG_TIMER_PERIOD: period_cfg = val[PERIOD_W-1:0];
			REG_SAMPLES:      spa_cfg = val[SPA_W-1:0];
			REG_GLITCH:       glitch_cfg = val[GLITCH_W-1:0];
			REG_TIMEOUT:      tmo_cfg = val[TMO_W-1:0];
			default: ;
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_regs(input logic [CFG_DATA_W-1:0] scale, input logic [CFG_DATA_W-1:0] period,
			input logic [CFG_DATA_W-1:0] spa, input logic [CFG_DATA_W-1:0] glitch,
			input logic [CFG_DATA_W-1:0] tmo);
		write_reg(REG_SPEED_SCALE, scale);
		write_reg(REG_TIMER_PERIOD, period);
		write_reg(REG_SAMPLES, spa);
		write_reg(REG_GLITCH, glitch);
		write_reg(REG_TIMEOUT, tmo);
	endtask

	// Random words: mostly rise/fall pairs per channel, with ticks and stray captures
	task automatic run_phase(input int n_items, input int fixed_ch, input int unsigned tick_pct,
			input int unsigned back_pct);
		evt_word_t   w;
		int unsigned pick;
		for (int i = 0; i < n_items; i++) begin
			w.channel = (fixed_ch >= 0) ? fixed_ch[CHAN_W-1:0] : CHAN_W'($urandom_range(0, 3));
			w.dir_pin = ($urandom_range(0, 99) < back_pct);
			w.capture_value = CAP_W'($urandom_range(0, 65535));
			if ($urandom_range(0, 99) < tick_pct) begin
				w.req_type = REQ_TICK;
			end else begin
				w.req_type = REQ_EDGE;
				if (arm_st[w.channel]) begin
					pick = $urandom_range(0, 99);
					if (pick < 60)
						w.capture_value = rise_st[w.channel] + CAP_W'($urandom_range(1, 2000));
					else if (pick < 75)
						w.capture_value = rise_st[w.channel] + CAP_W'($urandom_range(1, 20));
					else if (pick < 85)
						w.capture_value = rise_st[w.channel] + CAP_W'($urandom_range(2000, 65535));
					else if (pick < 92)
						w.capture_value = rise_st[w.channel];
				end
			end
			send_event(w, 1'b0, 0, 1'b0);
			if ($urandom_range(0, 99) < 2)
				wait_for_reports();
		end
		wait_for_reports();
	endtask

	// Result side: random stalls, plus one long hold-off on request
	initial begin
		int unsigned hold_left;
		int unsigned stall_left;
		hold_left = 0;
		stall_left = 0;
		res_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				hold_left = 600;
				long_hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				res_if.ready <= 1'b0;
				hold_left--;
			end else if (stall_left > 0) begin
				res_if.ready <= 1'b0;
				stall_left--;
			end else begin
				stall_left = pick_gap();
				if (stall_left > 0) begin
					res_if.ready <= 1'b0;
					stall_left--;
				end else begin
					res_if.ready <= 1'b1;
				end
			end
		end
	end

	// Report checker
	always @(posedge clk) begin
		res_word_t want;
		res_word_t got;
		if (arst_n && res_if.valid && res_if.ready) begin
			got = res_if.data;
			if (pending_reports.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected speed report: ch %0d speed %0d upd %0b",
						got.out_channel, got.speed, got.speed_updated);
			end else begin
				want = pending_reports.pop_front();
				n_checked++;
				if (want.speed_updated)
					n_changes++;
				if (got.out_channel !== want.out_channel || got.speed !== want.speed
						|| got.speed_updated !== want.speed_updated) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("Speed report %0d mismatch: expected ch %0d speed %0d upd %0b",
							n_checked, want.out_channel, want.speed, want.speed_updated);
						$display("  got ch %0d speed %0d upd %0b",
							got.out_channel, got.speed, got.speed_updated);
					end
				end
			end
		end
	end

	// Watchdog on cycles without any transfer
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || cfg_we || (evt_if.valid && evt_if.ready)
					|| (res_if.valid && res_if.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Watchdog: no transfer for %0d cycles, %0d reports outstanding",
			STALL_LIMIT, pending_reports.size());
		$display("** encoder_pulse_speed_estimator_unit: FAILED **");
		$finish;
	end

	initial begin
		evt_word_t w;
		arst_n <= 1'b0;
		evt_if.valid <= 1'b0;
		evt_if.data <= '0;
		cfg_we <= 1'b0;
		cfg_idx <= REG_SPEED_SCALE;
		cfg_wdata <= '0;
		for (int c = 0; c < 4; c++) begin
			arm_st[c] = 1'b0;
			rise_st[c] = '0;
			back_st[c] = 1'b0;
			ovf_st[c] = '0;
			acc_st[c] = '0;
			cnt_st[c] = '0;
			spd_st[c] = '0;
			first_st[c] = 1'b0;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_WRITE) begin
				wait_for_reports();
				write_reg(directed_rows[i].widx, directed_rows[i].wval);
			end else begin
				w.req_type = directed_rows[i].req;
				w.channel = directed_rows[i].ch;
				w.capture_value = directed_rows[i].cap;
				w.dir_pin = directed_rows[i].dir;
				send_event(w, directed_rows[i].typed, directed_rows[i].speed,
					directed_rows[i].upd);
			end
		end
		wait_for_reports();

		// defaults written back explicitly
		set_regs(24'd100000, 24'd10000, 24'd10, 24'd5120, 24'd3);
		run_phase(100, -1, 10, 20);

		// upper extremes of scale, period and timeout, back to back on both sides
		set_regs(24'd1048575, 24'd65535, 24'd1, 24'd0, 24'd15);
		no_idle = 1'b1;
		run_phase(100, -1, 8, 50);
		no_idle = 1'b0;

		// lower extremes, glitch bound at its top
		set_regs(24'd1, 24'd1, 24'd2, 24'd16777215, 24'd1);
		run_phase(80, -1, 20, 30);

		// random setting with a long hold-off on the result side
		set_regs(CFG_DATA_W'($urandom_range(1, 1048575)), CFG_DATA_W'($urandom_range(1, 65535)),
			CFG_DATA_W'($urandom_range(1, 6)), CFG_DATA_W'($urandom_range(0, 300000)),
			CFG_DATA_W'($urandom_range(1, 15)));
		long_hold_req = 1'b1;
		run_phase(120, -1, 12, 40);

		// deepest average on a single channel
		set_regs(24'd200000, 24'd20000, 24'd255, 24'd1000, 24'd15);
		run_phase(530, 2, 2, 10);

		set_regs(CFG_DATA_W'($urandom_range(1, 1048575)), CFG_DATA_W'($urandom_range(1, 65535)),
			CFG_DATA_W'($urandom_range(1, 4)), CFG_DATA_W'($urandom_range(0, 100000)),
			CFG_DATA_W'($urandom_range(1, 15)));
		run_phase(50, -1, 15, 50);

		wait_for_reports();
		repeat (100) @(posedge clk);
		if (pending_reports.size() != 0) begin
			mismatches += pending_reports.size();
			$display("%0d speed reports never arrived", pending_reports.size());
		end

		$display("Covered %0d event words (%0d ticks, %0d falling edges) over seven settings",
			n_checked, n_ticks, n_falls);
		$display("Checked %0d speed reports, %0d of them changing the speed; %0d mismatches",
			n_checked, n_changes, mismatches);
		if (mismatches == 0)
			$display("** encoder_pulse_speed_estimator_unit: PASSED **");
		else
			$display("** encoder_pulse_speed_estimator_unit: FAILED **");
		$finish;
	end

endmodule
